// ===== rtl/core/uss_pkg.sv =====
// Shared types and constants for the unique set store.
`default_nettype none
package uss_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_READ     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/uss_req_if.sv =====
// Request channel interface.
`default_nettype none
interface uss_req_if
  import uss_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output req_type, output value, output position, input ready);
  modport sink   (input valid, input req_type, input value, input position, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uss_rsp_if.sv =====
// Response channel interface.
`default_nettype none
interface uss_rsp_if
  import uss_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic                      found;
  logic signed [VALUE_W-1:0] element;
  logic [CNT_W-1:0]          count;

  modport source (output valid, output status, output found, output element, output count,
                  input ready);
  modport sink   (input valid, input status, input found, input element, input count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/uss_cell.sv =====
// One storage cell of the set: holds an entry, compares it, loads or takes its neighbor.
`default_nettype none
module uss_cell
  import uss_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic               occupied,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [VALUE_W-1:0] next_entry,
  output logic      [VALUE_W-1:0] entry,
  output logic                    match
);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = value;
    end else if (ctl.shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = occupied && (entry_r == value);

endmodule
`default_nettype wire

// ===== rtl/core/unique_set_store.sv =====
// Top level of the unique set store: a row of cells with shared request control.
// One request is taken per cycle. All cells compare the request value in parallel
// and a remove shifts the later cells down in the same cycle, so each transaction
// completes in the cycle it is accepted; its response appears in the output
// register on the next cycle. The output register lets a new request in while a
// response waits; input ready drops only while a response is held and the sink is
// not ready. Entries have no reset and need no clearing pass: only cells below the
// count are compared or read.
`default_nettype none
module unique_set_store
  import uss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  uss_req_if.sink   in_req,
  uss_rsp_if.source out_rsp
);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic               found_r;
  logic [VALUE_W-1:0] element_r;
  logic [CNT_W-1:0]   count_out_r;

  logic [VALUE_W-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]   match_w;
  cell_ctl_t          ctl_w [DEPTH];

  logic             accept;
  req_type_t        req;
  logic             hit;
  logic             full;
  logic             pos_ok;
  logic [CNT_W-1:0] pos_ext;
  status_t          status_nxt;
  logic             found_nxt;
  logic [VALUE_W-1:0] element_nxt;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign req          = req_type_t'(in_req.req_type);
  assign hit          = |match_w;
  assign full         = (count_r == CNT_W'(DEPTH));
  assign pos_ext      = CNT_W'(in_req.position);
  assign pos_ok       = (pos_ext < count_r);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX      = CNT_W'(k);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(k + 1);
    logic [VALUE_W-1:0] nbr;

    if (k == DEPTH - 1) begin : g_last
      assign nbr = entry_w[k];
    end else begin : g_mid
      assign nbr = entry_w[k + 1];
    end

    assign ctl_w[k].load  = accept && (req == REQ_ADD) && !hit && !full && (IDX == count_r);
    assign ctl_w[k].shift = accept && (req == REQ_REMOVE) && pos_ok &&
                            (IDX >= pos_ext) && (IDX_NEXT < count_r);

    uss_cell u_cell (
      .clk        (clk),
      .ctl        (ctl_w[k]),
      .occupied   (IDX < count_r),
      .value      (in_req.value),
      .next_entry (nbr),
      .entry      (entry_w[k]),
      .match      (match_w[k])
    );
  end

  always_comb begin
    status_nxt  = ST_DONE;
    found_nxt   = 1'b0;
    element_nxt = '0;
    count_nxt   = count_r;
    unique case (req)
      REQ_ADD: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (!pos_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_CONTAINS: begin
        found_nxt = hit;
      end
      REQ_READ: begin
        if (!pos_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          element_nxt = entry_w[IDX_W'(in_req.position)];
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      element_r   <= element_nxt;
      count_out_r <= count_nxt;
    end
  end

  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.status  = status_r;
  assign out_rsp.found   = found_r;
  assign out_rsp.element = element_r;
  assign out_rsp.count   = count_out_r;

endmodule
`default_nettype wire
